@@ rtl/core/clcd_pkg.sv @@
// Package for the character LCD bus sequencer: request, beat and config types,
// request codes, and the beat decode used by the sequencer core.
// No dependencies.
`timescale 1ns / 1ps

package clcd_pkg;

    localparam int IDX_W = 4;
    localparam logic [IDX_W-1:0] MAX_BEAT_IDX = 4'd13;

    localparam logic [1:0] MODE_CHAR   = 2'd0;
    localparam logic [1:0] MODE_CMD    = 2'd1;
    localparam logic [1:0] MODE_CURSOR = 2'd2;
    localparam logic [1:0] MODE_INIT   = 2'd3;

    localparam logic [1:0] WAIT_NONE  = 2'd0;
    localparam logic [1:0] WAIT_LONG  = 2'd1;
    localparam logic [1:0] WAIT_SHORT = 2'd2;
    localparam logic [1:0] WAIT_CLEAR = 2'd3;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FOUR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROWS = 2'd1;

    localparam logic [7:0] CMD_SET_DDRAM   = 8'h80;
    localparam logic [7:0] CMD_FUNC_8BIT   = 8'h30;
    localparam logic [7:0] CMD_FUNC_4BIT   = 8'h20;
    localparam logic [7:0] CMD_FUNC_2LINE  = 8'h08;
    localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0C;
    localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
    localparam logic [7:0] CMD_SHIFT       = 8'h14;
    localparam logic [7:0] CMD_CLEAR       = 8'h01;
    localparam logic [7:0] NIB_WAKE        = 8'h03;
    localparam logic [7:0] NIB_GO_4BIT     = 8'h02;

    typedef struct packed {
        logic       use_four;
        logic [4:0] rows;
    } t_cfg;

    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic [7:0] val;
    } t_req;

    typedef struct packed {
        logic       rs;
        logic [7:0] val;
        logic [1:0] wait_cls;
        logic       last;
    } t_beat;

    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] b;
        case (row)
            2'd0:    b = 8'h00;
            2'd1:    b = 8'h40;
            2'd2:    b = 8'h14;
            default: b = 8'h54;
        endcase
        return b;
    endfunction

    function automatic t_beat init_beat(input logic [IDX_W-1:0] idx, input t_cfg cfg);
        t_beat      bt;
        logic [IDX_W-1:0] pre;
        logic [IDX_W-1:0] j;
        logic [2:0] k;
        logic       half;
        logic [7:0] b;
        logic [1:0] w;
        bt.rs = 1'b0;
        pre = cfg.use_four ? 4'd4 : 4'd3;
        if (idx < pre) begin
            if (cfg.use_four) begin
                bt.val = (idx == 4'd3) ? NIB_GO_4BIT : NIB_WAKE;
            end else begin
                bt.val = CMD_FUNC_8BIT;
            end
            bt.wait_cls = WAIT_LONG;
            bt.last     = 1'b0;
        end else begin
            // skip the function-set slot (one byte) on a single-line display
            j    = idx - pre + ((cfg.rows > 5'd1) ? 4'd0 : (cfg.use_four ? 4'd2 : 4'd1));
            half = j[0];
            k    = cfg.use_four ? j[3:1] : j[2:0];
            case (k)
                3'd0: begin
                    b = (cfg.use_four ? CMD_FUNC_4BIT : CMD_FUNC_8BIT) | CMD_FUNC_2LINE;
                    w = WAIT_LONG;
                end
                3'd1: begin
                    b = CMD_DISPLAY_ON;
                    w = WAIT_SHORT;
                end
                3'd2: begin
                    b = CMD_ENTRY_MODE;
                    w = WAIT_SHORT;
                end
                3'd3: begin
                    b = CMD_SHIFT;
                    w = WAIT_SHORT;
                end
                default: begin
                    b = CMD_CLEAR;
                    w = WAIT_CLEAR;
                end
            endcase
            if (cfg.use_four) begin
                bt.val      = half ? {4'h0, b[3:0]} : {4'h0, b[7:4]};
                bt.wait_cls = half ? w : WAIT_NONE;
                bt.last     = (k == 3'd4) && half;
            end else begin
                bt.val      = b;
                bt.wait_cls = w;
                bt.last     = (k == 3'd4);
            end
        end
        return bt;
    endfunction

    function automatic t_beat byte_beat(input t_req req, input logic [IDX_W-1:0] idx,
                                        input logic four);
        t_beat bt;
        bt.rs       = req.rs;
        bt.wait_cls = WAIT_NONE;
        if (four) begin
            bt.val  = idx[0] ? {4'h0, req.val[3:0]} : {4'h0, req.val[7:4]};
            bt.last = idx[0];
        end else begin
            bt.val  = req.val;
            bt.last = 1'b1;
        end
        return bt;
    endfunction

endpackage

@@ rtl/core/clcd_beat_gen.sv @@
// Request register and beat counter: holds the current request and steps
// through its beats, one per cycle the output stage can take. Uses clcd_pkg.
`timescale 1ns / 1ps

module clcd_beat_gen import clcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_byte,
    input  logic [4:0]  i_column,
    input  logic [1:0]  i_row,
    output logic        o_beat_valid,
    input  logic        i_beat_ready,
    output t_beat       o_beat
);

    logic             r_busy, n_busy;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_four, n_four;
    t_req             r_req, n_req;
    logic             w_adv;
    logic             w_acc;

    always_comb begin
        if (r_req.is_init) begin
            o_beat = init_beat(r_idx, i_cfg);
        end else begin
            o_beat = byte_beat(r_req, r_idx, r_four);
        end
    end

    assign o_beat_valid = r_busy;
    assign w_adv        = r_busy && i_beat_ready;
    assign o_req_ready  = !r_busy || (w_adv && o_beat.last);
    assign w_acc        = i_req_valid && o_req_ready;

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        n_four = r_four;
        n_req  = r_req;
        if (w_adv) begin
            if (o_beat.last) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + 4'd1;
            end
        end
        if (w_acc) begin
            n_busy      = 1'b1;
            n_idx       = '0;
            n_req.is_init = (i_mode == MODE_INIT);
            n_req.rs    = (i_mode == MODE_CHAR);
            case (i_mode)
                MODE_CURSOR: n_req.val = (CMD_SET_DDRAM | row_base(i_row)) + {3'd0, i_column};
                default:     n_req.val = i_byte;
            endcase
            // 4-bit transfers take effect once the wake-up beats are out
            if (i_mode == MODE_INIT) begin
                n_four = i_cfg.use_four;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_four <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
            r_four <= n_four;
        end
        r_req <= n_req;
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= MAX_BEAT_IDX)
        else $error("beat index out of range");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_beat_ready |=> r_busy && $stable(r_idx))
        else $error("beat counter moved while stalled");

    a_accept_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && r_busy |-> w_adv && o_beat.last)
        else $error("request taken before previous request finished");

    a_byte_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !r_req.is_init |-> r_idx <= 4'd1)
        else $error("byte request ran past two beats");

endmodule

@@ rtl/core/clcd_out_reg.sv @@
// Output register for bus beats: takes a new beat whenever empty or being
// drained. Uses clcd_pkg.
`timescale 1ns / 1ps

module clcd_out_reg import clcd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_beat i_beat,
    output logic  o_valid,
    input  logic  i_ready,
    output t_beat o_beat
);

    logic  r_valid;
    t_beat r_beat;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_beat <= i_beat;
        end
    end

endmodule

@@ rtl/core/char_lcd_bus_sequencer.sv @@
// Top level of the character LCD bus sequencer: config registers, beat
// generator and output register. Uses clcd_pkg, clcd_beat_gen, clcd_out_reg.
//
//  channel   dir  tdata                              tuser / tlast
//  s_axis    in   byte_value[7:0] column[12:8]       tuser: mode[1:0]
//                 row[14:13]
//  m_axis    out  bus_value[7:0] wait_class[9:8]     tuser: register_select
//                                                    tlast: last_beat
//  cfg       in   i_cfg_idx, i_cfg_data[4:0]         write on i_cfg_we
//
// At most one beat leaves per cycle, when m_axis is not stalled: a byte request is one beat
// on an 8-bit bus and two on a 4-bit bus, initialization 7 to 14 beats, counted by the beat counter.
// The next request is taken in the cycle its predecessor's last beat moves on.
// Reset is synchronous, active low: 8-bit bus, two rows, outputs empty.
// A stall on m_axis holds the output register and the beat counter.
`timescale 1ns / 1ps

module char_lcd_bus_sequencer import clcd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [15:0]          i_s_axis_tdata,   // byte_value, column, row, pad
    input  logic [1:0]           i_s_axis_tuser,   // mode
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [15:0]          o_m_axis_tdata,   // bus_value, wait_class, pad
    output logic                 o_m_axis_tuser,   // register_select
    output logic                 o_m_axis_tlast,   // last_beat
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [4:0]           i_cfg_data
);

    t_cfg  r_cfg;
    logic  w_beat_valid;
    logic  w_beat_ready;
    t_beat w_beat;
    t_beat w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.use_four <= 1'b0;
            r_cfg.rows     <= 5'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_FOUR: r_cfg.use_four <= i_cfg_data[0];
                CFG_IDX_ROWS: r_cfg.rows     <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    clcd_beat_gen u_gen (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_req_valid  (i_s_axis_tvalid),
        .o_req_ready  (o_s_axis_tready),
        .i_mode       (i_s_axis_tuser),
        .i_byte       (i_s_axis_tdata[7:0]),
        .i_column     (i_s_axis_tdata[12:8]),
        .i_row        (i_s_axis_tdata[14:13]),
        .o_beat_valid (w_beat_valid),
        .i_beat_ready (w_beat_ready),
        .o_beat       (w_beat)
    );

    clcd_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_beat_valid),
        .o_ready (w_beat_ready),
        .i_beat  (w_beat),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_beat  (w_out)
    );

    assign o_m_axis_tdata = {6'd0, w_out.wait_cls, w_out.val};
    assign o_m_axis_tuser = w_out.rs;
    assign o_m_axis_tlast = w_out.last;

endmodule

@@ bench/tb_char_lcd_bus_sequencer.sv @@
// Testbench for char_lcd_bus_sequencer: drives requests and register writes,
// predicts every bus beat and checks each one in order. Uses clcd_pkg.
`timescale 1ns / 1ps

module tb_char_lcd_bus_sequencer;
    import clcd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

    // Tracks the bus mode and register copies; holds the beats still owed.
    class lcd_beat_scoreboard;
        logic       four_active;
        logic       cfg_four;
        logic [4:0] cfg_rows;
        t_beat      burst[$];
        t_beat      beats_due[$];
        int         errors;

        function new();
            four_active = 1'b0;
            cfg_four    = 1'b0;
            cfg_rows    = 5'd2;
            errors      = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [4:0] data);
            if (idx == CFG_IDX_FOUR)
                cfg_four = data[0];
            else if (idx == CFG_IDX_ROWS)
                cfg_rows = data;
        endfunction

        function void add_beat(input logic rs, input logic [7:0] val, input logic [1:0] w);
            t_beat bt;
            bt.rs       = rs;
            bt.val      = val;
            bt.wait_cls = w;
            bt.last     = 1'b0;
            burst.push_back(bt);
        endfunction

        function void add_byte(input logic rs, input logic [7:0] val, input logic [1:0] w);
            if (four_active) begin
                add_beat(rs, {4'h0, val[7:4]}, WAIT_NONE);
                add_beat(rs, {4'h0, val[3:0]}, w);
            end else begin
                add_beat(rs, val, w);
            end
        endfunction

        function logic [7:0] cursor_cmd(input logic [1:0] row, input logic [4:0] col);
            logic [7:0] base;
            case (row)
                2'd0:    base = 8'h00;
                2'd1:    base = 8'h40;
                2'd2:    base = 8'h14;
                default: base = 8'h54;
            endcase
            return (CMD_SET_DDRAM | base) + {3'b000, col};
        endfunction

        function void note_request(input logic [1:0] mode, input logic [7:0] b,
                                   input logic [4:0] col, input logic [1:0] row);
            logic [7:0] func;
            burst.delete();
            case (mode)
                MODE_CHAR:   add_byte(1'b1, b, WAIT_NONE);
                MODE_CMD:    add_byte(1'b0, b, WAIT_NONE);
                MODE_CURSOR: add_byte(1'b0, cursor_cmd(row, col), WAIT_NONE);
                default: begin
                    four_active = 1'b0;
                    if (cfg_four) begin
                        add_beat(1'b0, NIB_WAKE, WAIT_LONG);
                        add_beat(1'b0, NIB_WAKE, WAIT_LONG);
                        add_beat(1'b0, NIB_WAKE, WAIT_LONG);
                        add_beat(1'b0, NIB_GO_4BIT, WAIT_LONG);
                        four_active = 1'b1;
                        func = CMD_FUNC_4BIT;
                    end else begin
                        add_beat(1'b0, CMD_FUNC_8BIT, WAIT_LONG);
                        add_beat(1'b0, CMD_FUNC_8BIT, WAIT_LONG);
                        add_beat(1'b0, CMD_FUNC_8BIT, WAIT_LONG);
                        func = CMD_FUNC_8BIT;
                    end
                    if (cfg_rows > 5'd1)
                        add_byte(1'b0, func | CMD_FUNC_2LINE, WAIT_LONG);
                    add_byte(1'b0, CMD_DISPLAY_ON, WAIT_SHORT);
                    add_byte(1'b0, CMD_ENTRY_MODE, WAIT_SHORT);
                    add_byte(1'b0, CMD_SHIFT, WAIT_SHORT);
                    add_byte(1'b0, CMD_CLEAR, WAIT_CLEAR);
                end
            endcase
            burst[burst.size()-1].last = 1'b1;
            foreach (burst[i])
                beats_due.push_back(burst[i]);
        endfunction

        function void check_beat(input t_beat got);
            t_beat exp;
            if (beats_due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected beat: rs=%0d val=%02h wait=%0d last=%0d",
                             got.rs, got.val, got.wait_cls, got.last);
                return;
            end
            exp = beats_due.pop_front();
            if (got.rs != exp.rs || got.val != exp.val || got.wait_cls != exp.wait_cls ||
                got.last != exp.last) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("beat mismatch: exp rs=%0d val=%02h wait=%0d last=%0d",
                             exp.rs, exp.val, exp.wait_cls, exp.last);
                    $display("               got rs=%0d val=%02h wait=%0d last=%0d",
                             got.rs, got.val, got.wait_cls, got.last);
                end
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [15:0]          i_s_axis_tdata;   // byte_value, column, row, pad
    logic [1:0]           i_s_axis_tuser;   // mode
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [15:0]          o_m_axis_tdata;   // bus_value, wait_class, pad
    logic                 o_m_axis_tuser;   // register_select
    logic                 o_m_axis_tlast;   // last_beat
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [4:0]           i_cfg_data;

    lcd_beat_scoreboard beat_board;
    bit                 idle_on;
    int                 cycle_count;

    char_lcd_bus_sequencer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Leaves tvalid high on return so back-to-back requests need no gap.
    task automatic send_request(input logic [1:0] mode, input logic [7:0] b,
                                input logic [4:0] col, input logic [1:0] row);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, row, col, b};
        i_s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!o_s_axis_tready);
        beat_board.note_request(mode, b, col, row);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (beat_board.beats_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [4:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        beat_board.write_reg(idx, data);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_random();
        int         pick;
        logic [1:0] mode;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            mode = MODE_CHAR;
        else if (pick < 65)
            mode = MODE_CMD;
        else if (pick < 92)
            mode = MODE_CURSOR;
        else
            mode = MODE_INIT;
        send_request(mode, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                     2'($urandom_range(0, 3)));
    endtask

    // receive side: random stall before each beat while idle_on is set
    initial begin
        int    stall;
        t_beat got;
        i_m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            stall = idle_on ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            got.rs       = o_m_axis_tuser;
            got.val      = o_m_axis_tdata[7:0];
            got.wait_cls = o_m_axis_tdata[9:8];
            got.last     = o_m_axis_tlast;
            beat_board.check_beat(got);
        end
    end

    initial begin
        logic [4:0] rows_plan [8];
        logic       four_plan [8];
        int         per_phase;
        beat_board      = new();
        idle_on         = 1'b1;
        cycle_count     <= 0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= MODE_CHAR;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_IDX_FOUR;
        i_cfg_data      <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 8-bit bus straight out of reset, field extremes
        send_request(MODE_CHAR, 8'h00, 5'd0, 2'd0);
        send_request(MODE_CHAR, 8'hFF, 5'd31, 2'd3);
        send_request(MODE_CMD, 8'h00, 5'd31, 2'd3);
        send_request(MODE_CMD, 8'hFF, 5'd0, 2'd0);
        send_request(MODE_CURSOR, 8'hFF, 5'd0, 2'd0);
        send_request(MODE_CURSOR, 8'h00, 5'd31, 2'd1);
        send_request(MODE_CURSOR, 8'hFF, 5'd5, 2'd2);
        send_request(MODE_CURSOR, 8'h00, 5'd31, 2'd3);
        drain();
        // bus width only changes at the next initialization
        program_reg(CFG_IDX_FOUR, 5'd1);
        send_request(MODE_CHAR, 8'h5A, 5'd0, 2'd0);
        send_request(MODE_INIT, 8'hFF, 5'd31, 2'd3);
        send_request(MODE_CHAR, 8'hA5, 5'd0, 2'd0);
        send_request(MODE_CMD, 8'h3C, 5'd17, 2'd1);
        send_request(MODE_CURSOR, 8'hFF, 5'd31, 2'd3);
        drain();
        program_reg(CFG_IDX_ROWS, 5'd0);
        send_request(MODE_INIT, 8'h00, 5'd0, 2'd0);
        drain();
        program_reg(CFG_IDX_FOUR, 5'd0);
        send_request(MODE_CHAR, 8'hC3, 5'd0, 2'd0);
        send_request(MODE_INIT, 8'h00, 5'd0, 2'd0);
        send_request(MODE_CMD, 8'h81, 5'd0, 2'd0);
        drain();
        program_reg(CFG_IDX_ROWS, 5'd20);
        program_reg(CFG_IDX_SPARE_LO, 5'd31);
        program_reg(CFG_IDX_SPARE_HI, 5'd1);
        send_request(MODE_INIT, 8'h00, 5'd0, 2'd0);
        send_request(MODE_CHAR, 8'h41, 5'd0, 2'd0);
        drain();

        four_plan = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
        rows_plan = '{5'd2, 5'd0, 5'd20, 5'd20, 5'd1, 5'd1, 5'd0, 5'd2};
        for (int ph = 0; ph < 8; ph++) begin
            program_reg(CFG_IDX_FOUR, {4'b0000, four_plan[ph]});
            program_reg(CFG_IDX_ROWS, rows_plan[ph]);
            if ($urandom_range(0, 3) == 0)
                program_reg(CFG_IDX_SPARE_LO + 2'($urandom_range(0, 1)),
                            5'($urandom_range(0, 31)));
            idle_on = ($urandom_range(0, 3) != 0);
            per_phase = 40 + $urandom_range(0, 10);
            send_request(MODE_INIT, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                         2'($urandom_range(0, 3)));
            for (int n = 0; n < per_phase; n++) begin
                if (n % 16 == 15)
                    idle_on = ($urandom_range(0, 3) != 0);
                send_random();
            end
            drain();
            // one rows write with a random in-range value between phases
            program_reg(CFG_IDX_ROWS, 5'($urandom_range(0, 20)));
            send_request(MODE_INIT, 8'h00, 5'd0, 2'd0);
            send_random();
            drain();
        end

        idle_on = 1'b0;
        repeat (20) @(posedge i_clk);
        if (beat_board.errors == 0 && beat_board.beats_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
